// ===== sv/sbmp_pkg.sv =====
package sbmp_pkg;

    localparam int DEF_MASK_WIDTH  = 256;
    localparam int DEF_MASK_HEIGHT = 256;
    localparam int DEF_MAX_DABS    = 65535;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_RADIUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_HARDNESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_OPACITY  = 3'd4;

    // request kinds
    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_BEGIN = 3'd2;
    localparam logic [2:0] REQ_MOVE  = 3'd3;
    localparam logic [2:0] REQ_END   = 3'd4;
    localparam logic [2:0] REQ_CLEAR = 3'd5;
    localparam logic [2:0] REQ_FILL  = 3'd6;

    // result status
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    // shared arithmetic units
    localparam int SQ_IN_W   = 42;
    localparam int SQ_OUT_W  = 21;
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 21;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ===== sv/soft_brush_mask_painter.sv =====
// Channel      | Dir | Signals                        | Payload
// -------------+-----+--------------------------------+---------------------------------
// request      | in  | i_s_axis_tvalid/o_s_axis_tready| tuser: req_type[2:0]
//              |     | i_s_axis_tdata[63:0]           | tdata: point_x, point_y, erase_mode,
//              |     |                                |   cell_column, cell_row, load_value
// result       | out | o_m_axis_tvalid/i_m_axis_tready| tdata: read_value; tuser: status
// config       | in  | i_cfg_we/i_cfg_index/i_cfg_data| register write, no handshake
//
// One request at a time. Clear and fill: one pixel written per cycle over the active area.
// Paint: brush setup (PRE1, PRE2) per item; a move first computes its length and dab
// count on the shared 21-step square root and 40-step divider. Each dab of a move needs
// two rounding divisions. Pixels of the dab box outside the radius are not written; the
// hard core needs no root or division, and the soft ring uses the square root and divider.
// Reset is synchronous; the mask memory is not cleared. A result held by a stalled
// output does not block the next transfer from being accepted.
module soft_brush_mask_painter #(
    parameter int MASK_WIDTH  = sbmp_pkg::DEF_MASK_WIDTH,
    parameter int MASK_HEIGHT = sbmp_pkg::DEF_MASK_HEIGHT,
    parameter int MAX_DABS    = sbmp_pkg::DEF_MAX_DABS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [15:0] point_x, [31:16] point_y, [32] erase_mode, [40:33] cell_column,
    // [48:41] cell_row, [56:49] load_value, [63:57] zero
    input  logic [63:0]                      i_s_axis_tdata,
    // [2:0] req_type
    input  logic [2:0]                       i_s_axis_tuser,
    // result channel
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] read_value
    output logic [7:0]                       o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]                       o_m_axis_tuser,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [sbmp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbmp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int XW  = (MASK_WIDTH > 1) ? $clog2(MASK_WIDTH) : 1;
    localparam int YW  = (MASK_HEIGHT > 1) ? $clog2(MASK_HEIGHT) : 1;
    localparam int AW  = XW + YW;
    localparam int NW  = $clog2(MAX_DABS + 1);
    localparam int QW  = sbmp_pkg::DIV_NUM_W;
    localparam int DW  = sbmp_pkg::DIV_DEN_W;

    typedef enum logic [26:0] {
        ST_IDLE   = 27'd1 << 0,
        ST_DEC    = 27'd1 << 1,
        ST_RD     = 27'd1 << 2,
        ST_MV_SQX = 27'd1 << 3,
        ST_MV_SQY = 27'd1 << 4,
        ST_MV_RT  = 27'd1 << 5,
        ST_MV_DIV = 27'd1 << 6,
        ST_PRE1   = 27'd1 << 7,
        ST_PRE2   = 27'd1 << 8,
        ST_DAB    = 27'd1 << 9,
        ST_OX     = 27'd1 << 10,
        ST_OY     = 27'd1 << 11,
        ST_BOX    = 27'd1 << 12,
        ST_PIX    = 27'd1 << 13,
        ST_SQX    = 27'd1 << 14,
        ST_SQY    = 27'd1 << 15,
        ST_CHK    = 27'd1 << 16,
        ST_RT     = 27'd1 << 17,
        ST_TDIV   = 27'd1 << 18,
        ST_SM1    = 27'd1 << 19,
        ST_SM2    = 27'd1 << 20,
        ST_SM3    = 27'd1 << 21,
        ST_MULK   = 27'd1 << 22,
        ST_WR     = 27'd1 << 23,
        ST_ADV    = 27'd1 << 24,
        ST_FILL   = 27'd1 << 25,
        ST_DONE   = 27'd1 << 26
    } t_state;

    // round a/16 half away from zero
    function automatic logic signed [12:0] f_round16(input logic signed [15:0] a);
        logic [16:0] ma;
        logic [16:0] q;
        ma = a[15] ? (17'd0 - {a[15], a}) : {1'b0, a};
        q  = (ma + 17'd8) >> 4;
        return a[15] ? -$signed(q[12:0]) : $signed(q[12:0]);
    endfunction

    t_state r_state;

    // configuration registers
    logic [8:0]  r_act_w;
    logic [8:0]  r_act_h;
    logic [12:0] r_radius;
    logic [8:0]  r_hard;
    logic [8:0]  r_opac;

    // request fields
    logic [2:0]         r_req;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [7:0]         r_col;
    logic [7:0]         r_row;
    logic [7:0]         r_lv;

    // stroke state
    logic               r_active;
    logic               r_erases;
    logic signed [15:0] r_prev_x;
    logic signed [15:0] r_prev_y;

    // move and dab sequencing
    logic signed [16:0] r_dx;
    logic signed [16:0] r_dy;
    logic [35:0]        r_d2;
    logic               r_exact;
    logic               r_single;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_i;
    logic signed [33:0] r_accx;
    logic signed [33:0] r_accy;
    logic signed [16:0] r_ox;
    logic signed [15:0] r_cxq;
    logic signed [15:0] r_cyq;
    logic [20:0]        r_hq;
    logic [25:0]        r_r2;
    logic [41:0]        r_hq2;

    // pixel walk
    logic [8:0]         r_px;
    logic [8:0]         r_py;
    logic [8:0]         r_x0;
    logic [8:0]         r_x1;
    logic [8:0]         r_y1;
    logic signed [17:0] r_ddx;
    logic signed [17:0] r_ddy;
    logic [7:0]         r_old;
    logic [16:0]        r_t;
    logic [33:0]        r_tt;
    logic [51:0]        r_prod;
    logic [16:0]        r_cov;
    logic [24:0]        r_k;

    // result
    logic [7:0] r_rv;
    logic [1:0] r_st;
    logic       r_out_valid;
    logic [7:0] r_out_rv;
    logic [1:0] r_out_st;

    // shared units
    logic                  r_sq_go;
    logic [41:0]           r_sq_val;
    logic                  r_div_go;
    logic [QW-1:0]         r_div_num;
    logic [DW-1:0]         r_div_den;
    sbmp_pkg::t_unit_stat  sq_stat;
    sbmp_pkg::t_unit_stat  div_stat;
    logic [20:0]           sq_root;
    logic                  sq_exact;
    logic [QW-1:0]         div_quo;
    logic [DW-1:0]         div_rem;

    // memory port
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_q;

    // ---------------------------------------------------------------- derived config
    localparam logic [12:0] MW = 13'(MASK_WIDTH);
    localparam logic [12:0] MH = 13'(MASK_HEIGHT);

    logic [8:0]  eff_w;
    logic [8:0]  eff_h;
    logic        has_mask;
    logic [12:0] rc;
    logic [8:0]  hdc;
    logic [8:0]  opc;
    logic [12:0] sp;
    logic [9:0]  ir;
    logic [13:0] rc15;
    logic [20:0] rq;

    assign eff_w    = ({4'b0, r_act_w} < MW) ? r_act_w : 9'(MW);
    assign eff_h    = ({4'b0, r_act_h} < MH) ? r_act_h : 9'(MH);
    assign has_mask = (eff_w != 9'd0) && (eff_h != 9'd0);
    assign rc       = (r_radius < 13'd16) ? 13'd16 : r_radius;
    assign hdc      = (r_hard > 9'd256) ? 9'd256 : r_hard;
    assign opc      = (r_opac > 9'd256) ? 9'd256 : r_opac;
    assign sp       = (rc < 13'd64) ? 13'd64 : rc;
    assign rc15     = {1'b0, rc} + 14'd15;
    assign ir       = rc15[13:4];
    assign rq       = {rc, 8'b0};

    // ---------------------------------------------------------------- request unpack
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;

    assign in_x = i_s_axis_tdata[15:0];
    assign in_y = i_s_axis_tdata[31:16];
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // ---------------------------------------------------------------- shared squarer
    logic signed [17:0] sq_in;
    logic signed [35:0] sq_out;
    logic [35:0]        d2_sum;

    always_comb begin
        case (r_state)
            ST_MV_SQX: sq_in = {r_dx[16], r_dx};
            ST_MV_SQY: sq_in = {r_dy[16], r_dy};
            ST_SQX:    sq_in = r_ddx;
            default:   sq_in = r_ddy;
        endcase
    end

    assign sq_out = 36'(sq_in) * 36'(sq_in);
    assign d2_sum = r_d2 + sq_out;

    // ---------------------------------------------------------------- dab box
    logic signed [12:0] cx;
    logic signed [12:0] cy;
    logic signed [14:0] lo_x;
    logic signed [14:0] hi_x;
    logic signed [14:0] lo_y;
    logic signed [14:0] hi_y;
    logic signed [14:0] wm1;
    logic signed [14:0] hm1;
    logic signed [14:0] bx0;
    logic signed [14:0] bx1;
    logic signed [14:0] by0;
    logic signed [14:0] by1;
    logic               box_empty;

    assign cx   = f_round16(r_cxq);
    assign cy   = f_round16(r_cyq);
    assign lo_x = 15'(cx) - $signed({5'b0, ir});
    assign hi_x = 15'(cx) + $signed({5'b0, ir});
    assign lo_y = 15'(cy) - $signed({5'b0, ir});
    assign hi_y = 15'(cy) + $signed({5'b0, ir});
    assign wm1  = $signed({6'b0, eff_w}) - 15'sd1;
    assign hm1  = $signed({6'b0, eff_h}) - 15'sd1;
    assign bx0  = (lo_x < 15'sd0) ? 15'sd0 : lo_x;
    assign bx1  = (hi_x > wm1) ? wm1 : hi_x;
    assign by0  = (lo_y < 15'sd0) ? 15'sd0 : lo_y;
    assign by1  = (hi_y > hm1) ? hm1 : hi_y;
    assign box_empty = (bx0 > bx1) || (by0 > by1);

    // pixel offset from the dab center in 1/16 px
    logic signed [17:0] ddx;
    logic signed [17:0] ddy;

    assign ddx = $signed({5'b0, r_px, 4'b0}) - {{2{r_cxq[15]}}, r_cxq};
    assign ddy = $signed({5'b0, r_py, 4'b0}) - {{2{r_cyq[15]}}, r_cyq};

    // ---------------------------------------------------------------- dab placement
    logic signed [33:0] nx_acc;
    logic [33:0]        ax;
    logic [33:0]        ay;
    logic [QW-1:0]      rdiv_num_x;
    logic [QW-1:0]      rdiv_num_y;
    logic [DW-1:0]      rdiv_den;
    logic signed [16:0] quo_s;

    assign nx_acc     = r_accx + 34'(r_dx);
    assign ax         = nx_acc[33] ? 34'(-nx_acc) : 34'(nx_acc);
    assign ay         = r_accy[33] ? 34'(-r_accy) : 34'(r_accy);
    assign rdiv_num_x = QW'({ax, 1'b0}) + QW'(r_n);
    assign rdiv_num_y = QW'({ay, 1'b0}) + QW'(r_n);
    assign rdiv_den   = DW'({r_n, 1'b0});
    assign quo_s      = $signed(div_quo[16:0]);

    // dab count for a move
    logic [QW:0] n_raw;
    logic [NW-1:0] n_cap;

    assign n_raw = r_exact ? ({1'b0, div_quo} + {{QW{1'b0}}, (div_rem != '0)})
                           : ({1'b0, div_quo} + (QW+1)'(1));
    always_comb begin
        if (n_raw > (QW+1)'(MAX_DABS)) begin
            n_cap = NW'(MAX_DABS);
        end else if (n_raw == '0) begin
            n_cap = NW'(1);
        end else begin
            n_cap = NW'(n_raw);
        end
    end

    // ---------------------------------------------------------------- coverage math
    logic [20:0] soft_num;
    logic [17:0] sm_m;
    logic [52:0] sm_sum;
    logic [20:0] sm_s;
    logic [32:0] k255;
    logic [32:0] dab_sum;
    logic [8:0]  dab_val;
    logic [24:0] keep;
    logic [33:0] er_sum;
    logic [9:0]  er_val;
    logic [7:0]  new_val;

    assign soft_num = (sq_root > r_hq) ? (sq_root - r_hq) : 21'd0;
    assign sm_m     = 18'd196608 - {r_t, 1'b0};
    assign sm_sum   = {1'b0, r_prod} + (53'd1 << 31);
    assign sm_s     = sm_sum[52:32];
    assign k255     = {r_k, 8'b0} - {8'b0, r_k};
    assign dab_sum  = k255 + (33'd1 << 23);
    assign dab_val  = dab_sum[32:24];
    assign keep     = 25'(25'd1 << 24) - r_k;
    assign er_sum   = 34'(r_old) * 34'(keep) + (34'd1 << 23);
    assign er_val   = er_sum[33:24];

    always_comb begin
        if (r_erases) begin
            new_val = (er_val > 10'd255) ? 8'd255 : er_val[7:0];
        end else begin
            new_val = (dab_val > {1'b0, r_old}) ? dab_val[7:0] : r_old;
        end
    end

    // ---------------------------------------------------------------- memory addressing
    logic [12:0] px13;
    logic [12:0] py13;
    logic [12:0] col13;
    logic [12:0] row13;
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] req_addr;
    logic          req_in_range;

    assign px13     = {4'b0, r_px};
    assign py13     = {4'b0, r_py};
    assign col13    = {5'b0, r_col};
    assign row13    = {5'b0, r_row};
    assign pix_addr = {py13[YW-1:0], px13[XW-1:0]};
    assign req_addr = {row13[YW-1:0], col13[XW-1:0]};
    assign req_in_range = ({1'b0, r_col} < eff_w) && ({1'b0, r_row} < eff_h);

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = pix_addr;
        mem_raddr = pix_addr;
        mem_wdata = new_val;
        case (r_state)
            ST_DEC: begin
                mem_waddr = req_addr;
                mem_raddr = req_addr;
                mem_wdata = r_lv;
                mem_we    = (r_req == sbmp_pkg::REQ_LOAD) && req_in_range;
                mem_re    = (r_req == sbmp_pkg::REQ_READ) && req_in_range;
            end
            ST_PIX: mem_re = 1'b1;
            ST_WR:  mem_we = 1'b1;
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = (r_req == sbmp_pkg::REQ_FILL) ? 8'hFF : 8'h00;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // walk the box row by row
    logic last_col;
    logic last_row;

    assign last_col = (r_px == r_x1);
    assign last_row = (r_py == r_y1);

    // ---------------------------------------------------------------- config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_w  <= 9'd0;
            r_act_h  <= 9'd0;
            r_radius <= 13'd16;
            r_hard   <= 9'd0;
            r_opac   <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbmp_pkg::CFG_ACTIVE_WIDTH:   r_act_w  <= i_cfg_data[8:0];
                sbmp_pkg::CFG_ACTIVE_HEIGHT:  r_act_h  <= i_cfg_data[8:0];
                sbmp_pkg::CFG_BRUSH_RADIUS:   r_radius <= i_cfg_data;
                sbmp_pkg::CFG_BRUSH_HARDNESS: r_hard   <= i_cfg_data[8:0];
                sbmp_pkg::CFG_BRUSH_OPACITY:  r_opac   <= i_cfg_data[8:0];
                default: r_act_w <= r_act_w;
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_erases    <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_out_valid <= 1'b0;
            r_sq_go     <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            r_sq_go  <= 1'b0;
            r_div_go <= 1'b0;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_req   <= i_s_axis_tuser;
                        r_x     <= in_x;
                        r_y     <= in_y;
                        r_col   <= i_s_axis_tdata[40:33];
                        r_row   <= i_s_axis_tdata[48:41];
                        r_lv    <= i_s_axis_tdata[56:49];
                        r_rv    <= 8'd0;
                        r_st    <= sbmp_pkg::STAT_IGNORED;
                        if (i_s_axis_tuser == sbmp_pkg::REQ_BEGIN) begin
                            r_erases <= i_s_axis_tdata[32];
                        end
                        r_state <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_state <= ST_DONE;
                    case (r_req)
                        sbmp_pkg::REQ_LOAD: begin
                            r_st <= req_in_range ? sbmp_pkg::STAT_DONE : sbmp_pkg::STAT_RANGE;
                        end
                        sbmp_pkg::REQ_READ: begin
                            if (req_in_range) begin
                                r_state <= ST_RD;
                            end else begin
                                r_st <= sbmp_pkg::STAT_RANGE;
                            end
                        end
                        sbmp_pkg::REQ_BEGIN: begin
                            r_active <= 1'b1;
                            r_prev_x <= r_x;
                            r_prev_y <= r_y;
                            r_single <= 1'b1;
                            r_n      <= NW'(1);
                            r_i      <= '0;
                            if (has_mask) begin
                                r_state <= ST_PRE1;
                            end
                        end
                        sbmp_pkg::REQ_MOVE: begin
                            r_dx     <= 17'(r_x) - 17'(r_prev_x);
                            r_dy     <= 17'(r_y) - 17'(r_prev_y);
                            r_single <= 1'b0;
                            r_i      <= '0;
                            r_accx   <= '0;
                            r_accy   <= '0;
                            if (r_active && has_mask) begin
                                r_state <= ST_MV_SQX;
                            end
                        end
                        sbmp_pkg::REQ_END: begin
                            r_active <= 1'b0;
                            r_st     <= sbmp_pkg::STAT_DONE;
                        end
                        sbmp_pkg::REQ_CLEAR, sbmp_pkg::REQ_FILL: begin
                            r_px <= '0;
                            r_py <= '0;
                            r_x0 <= '0;
                            r_x1 <= eff_w - 9'd1;
                            r_y1 <= eff_h - 9'd1;
                            if (has_mask) begin
                                r_state <= ST_FILL;
                            end
                        end
                        default: r_st <= sbmp_pkg::STAT_IGNORED;
                    endcase
                end
                ST_RD: begin
                    r_rv    <= mem_q;
                    r_st    <= sbmp_pkg::STAT_DONE;
                    r_state <= ST_DONE;
                end
                // segment length and dab count
                ST_MV_SQX: begin
                    r_d2    <= sq_out;
                    r_state <= ST_MV_SQY;
                end
                ST_MV_SQY: begin
                    r_d2 <= d2_sum;
                    if (d2_sum == '0) begin
                        r_single <= 1'b1;
                        r_n      <= NW'(1);
                        r_state  <= ST_PRE1;
                    end else begin
                        r_sq_val <= {4'b0, d2_sum[33:0], 4'b0};
                        r_sq_go  <= 1'b1;
                        r_state  <= ST_MV_RT;
                    end
                end
                ST_MV_RT: begin
                    if (sq_stat.done) begin
                        r_exact   <= sq_exact;
                        r_div_num <= QW'(sq_root);
                        r_div_den <= DW'(sp);
                        r_div_go  <= 1'b1;
                        r_state   <= ST_MV_DIV;
                    end
                end
                ST_MV_DIV: begin
                    if (div_stat.done) begin
                        r_n     <= n_cap;
                        r_state <= ST_PRE1;
                    end
                end
                // per-item brush constants
                ST_PRE1: begin
                    r_hq    <= 21'(rc) * 21'(hdc);
                    r_r2    <= 26'(rc) * 26'(rc);
                    r_state <= ST_PRE2;
                end
                ST_PRE2: begin
                    r_hq2   <= 42'(r_hq) * 42'(r_hq);
                    r_state <= ST_DAB;
                end
                ST_DAB: begin
                    if (r_i == r_n) begin
                        r_st <= sbmp_pkg::STAT_DONE;
                        if (r_req == sbmp_pkg::REQ_MOVE) begin
                            r_prev_x <= r_x;
                            r_prev_y <= r_y;
                        end
                        r_state <= ST_DONE;
                    end else begin
                        r_i <= r_i + NW'(1);
                        if (r_single) begin
                            r_cxq   <= r_x;
                            r_cyq   <= r_y;
                            r_state <= ST_BOX;
                        end else begin
                            r_accx    <= nx_acc;
                            r_accy    <= r_accy + 34'(r_dy);
                            r_div_num <= rdiv_num_x;
                            r_div_den <= rdiv_den;
                            r_div_go  <= 1'b1;
                            r_state   <= ST_OX;
                        end
                    end
                end
                ST_OX: begin
                    if (div_stat.done) begin
                        r_ox      <= r_accx[33] ? -quo_s : quo_s;
                        r_div_num <= rdiv_num_y;
                        r_div_go  <= 1'b1;
                        r_state   <= ST_OY;
                    end
                end
                ST_OY: begin
                    if (div_stat.done) begin
                        r_cxq   <= 16'(17'(r_prev_x) + r_ox);
                        r_cyq   <= 16'(17'(r_prev_y) + (r_accy[33] ? -quo_s : quo_s));
                        r_state <= ST_BOX;
                    end
                end
                ST_BOX: begin
                    if (box_empty) begin
                        r_state <= ST_DAB;
                    end else begin
                        r_x0    <= 9'(bx0);
                        r_x1    <= 9'(bx1);
                        r_y1    <= 9'(by1);
                        r_px    <= 9'(bx0);
                        r_py    <= 9'(by0);
                        r_state <= ST_PIX;
                    end
                end
                // per pixel: read, distance, coverage, write back inside the radius
                ST_PIX: begin
                    r_ddx   <= ddx;
                    r_ddy   <= ddy;
                    r_state <= ST_SQX;
                end
                ST_SQX: begin
                    r_d2    <= sq_out;
                    r_state <= ST_SQY;
                end
                ST_SQY: begin
                    r_d2    <= d2_sum;
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    r_old <= mem_q;
                    if (r_d2 > {10'b0, r_r2}) begin
                        r_state <= ST_ADV;
                    end else if ({r_d2[25:0], 16'b0} <= r_hq2) begin
                        r_cov   <= 17'd65536;
                        r_state <= ST_MULK;
                    end else if (rq <= r_hq) begin
                        r_cov   <= 17'd0;
                        r_state <= ST_MULK;
                    end else begin
                        r_sq_val <= {r_d2[25:0], 16'b0};
                        r_sq_go  <= 1'b1;
                        r_state  <= ST_RT;
                    end
                end
                ST_RT: begin
                    if (sq_stat.done) begin
                        r_div_num <= QW'({soft_num, 16'b0});
                        r_div_den <= rq - r_hq;
                        r_div_go  <= 1'b1;
                        r_state   <= ST_TDIV;
                    end
                end
                ST_TDIV: begin
                    if (div_stat.done) begin
                        r_t     <= (div_quo > QW'(65536)) ? 17'd65536 : div_quo[16:0];
                        r_state <= ST_SM1;
                    end
                end
                ST_SM1: begin
                    r_tt    <= 34'(r_t) * 34'(r_t);
                    r_state <= ST_SM2;
                end
                ST_SM2: begin
                    r_prod  <= 52'(r_tt) * 52'(sm_m);
                    r_state <= ST_SM3;
                end
                ST_SM3: begin
                    r_cov   <= (sm_s >= 21'd65536) ? 17'd0 : 17'(21'd65536 - sm_s);
                    r_state <= ST_MULK;
                end
                ST_MULK: begin
                    r_k     <= 25'(r_cov) * 25'(opc);
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    r_state <= ST_ADV;
                end
                ST_ADV: begin
                    if (!last_col) begin
                        r_px    <= r_px + 9'd1;
                        r_state <= ST_PIX;
                    end else if (!last_row) begin
                        r_px    <= r_x0;
                        r_py    <= r_py + 9'd1;
                        r_state <= ST_PIX;
                    end else begin
                        r_state <= ST_DAB;
                    end
                end
                ST_FILL: begin
                    if (!last_col) begin
                        r_px <= r_px + 9'd1;
                    end else if (!last_row) begin
                        r_px <= '0;
                        r_py <= r_py + 9'd1;
                    end else begin
                        r_st    <= sbmp_pkg::STAT_DONE;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_rv    <= r_rv;
                        r_out_st    <= r_st;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_rv;
    assign o_m_axis_tuser  = r_out_st;

    // ---------------------------------------------------------------- units
    sbmp_mem #(
        .AW(AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    sbmp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_value (r_sq_val),
        .o_stat  (sq_stat),
        .o_root  (sq_root),
        .o_exact (sq_exact)
    );

    sbmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

endmodule

// ===== sv/sbmp_mem.sv =====
module sbmp_mem #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_ram [2**AW];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ram[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_ram[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== sv/sbmp_isqrt.sv =====
module sbmp_isqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sbmp_pkg::SQ_IN_W-1:0]   i_value,
    output sbmp_pkg::t_unit_stat           o_stat,
    output logic [sbmp_pkg::SQ_OUT_W-1:0]  o_root,
    output logic                           o_exact
);

    localparam int W     = sbmp_pkg::SQ_IN_W;
    localparam int STEPS = W / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [W-1:0]  r_v;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_bit;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W-1:0]  trial;

    assign trial = r_r + r_bit;

    // one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_value;
                r_r    <= '0;
                r_bit  <= W'(1) << (W - 2);
                r_cnt  <= CW'(STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_r[sbmp_pkg::SQ_OUT_W-1:0];
    assign o_exact     = (r_v == '0);

endmodule

// ===== sv/sbmp_div.sv =====
module sbmp_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sbmp_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [sbmp_pkg::DIV_DEN_W-1:0]  i_den,
    output sbmp_pkg::t_unit_stat            o_stat,
    output logic [sbmp_pkg::DIV_NUM_W-1:0]  o_quo,
    output logic [sbmp_pkg::DIV_DEN_W-1:0]  o_rem
);

    localparam int NW = sbmp_pkg::DIV_NUM_W;
    localparam int DW = sbmp_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   sh;
    logic          fits;

    assign sh   = {r_rem, r_q[NW-1]};
    assign fits = (sh >= {1'b0, r_den});

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? DW'(sh - {1'b0, r_den}) : DW'(sh);
                r_q   <= {r_q[NW-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_q;
    assign o_rem       = r_rem;

endmodule

// ===== sv/sbmp_checker.sv =====
module sbmp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [63:0]                      i_s_axis_tdata,
    input logic [2:0]                       i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [7:0]                       o_m_axis_tdata,
    input logic [1:0]                       o_m_axis_tuser,
    input logic                             i_cfg_we,
    input logic [sbmp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [sbmp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != 2'd3)
        else $error("undefined status code");

    // only a successful read carries data
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != sbmp_pkg::STAT_DONE |->
        o_m_axis_tdata == 8'd0)
        else $error("value on a failed request");

    // one request in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second transfer taken while busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("bad state after reset");

endmodule

bind soft_brush_mask_painter sbmp_checker u_sbmp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .i_cfg_we        (i_cfg_we),
    .i_cfg_index     (i_cfg_index),
    .i_cfg_data      (i_cfg_data)
);

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MW = sbmp_pkg::DEF_MASK_WIDTH;
    localparam int MH = sbmp_pkg::DEF_MASK_HEIGHT;
    localparam int MAXD = sbmp_pkg::DEF_MAX_DABS;
    // generous, so that a full-range move can finish
    localparam int unsigned CYCLE_LIMIT = 60_000_000;
    localparam int RANDOM_ITEMS = 140;

    bit i_clk = 0;
    logic i_rst_n = 0;
    logic i_s_axis_tvalid = 0;
    logic o_s_axis_tready;
    // [15:0] point_x, [31:16] point_y, [32] erase_mode, [40:33] cell_column,
    // [48:41] cell_row, [56:49] load_value, [63:57] zero
    logic [63:0] i_s_axis_tdata = '0;
    // [2:0] req_type
    logic [2:0] i_s_axis_tuser = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 0;
    // [7:0] read_value
    logic [7:0] o_m_axis_tdata;
    // [1:0] status
    logic [1:0] o_m_axis_tuser;
    logic i_cfg_we = 0;
    logic [sbmp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sbmp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    soft_brush_mask_painter dut (.*);

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Mask predictor: own copy of the pixel store, stroke state and
    // brush registers, updated as each request is handed to the block.
    // ---------------------------------------------------------------
    typedef struct packed {
        logic [7:0] value;
        logic [1:0] status;
    } paint_result_t;

    paint_result_t pending_results[$];

    byte unsigned mask_img [MW*MH];
    bit stroke_on, stroke_sub;
    int prev_x, prev_y;
    int unsigned act_w, act_h, radius_q, hard_q, opac_q;

    int err_count = 0;
    int items_sent = 0;
    bit idle_en = 1;          // random idle bursts on both sides
    bit hold_go = 0;          // request a long receiver hold-off
    int hold_cnt = 0;
    int stall_left = 0;
    int unsigned cycle_cnt = 0;

    function automatic int width_used();
        return act_w < MW ? act_w : MW;
    endfunction

    function automatic int height_used();
        return act_h < MH ? act_h : MH;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // a/16 rounded half away from zero
    function automatic int half16(int a);
        return a >= 0 ? (a + 8) / 16 : -((-a + 8) / 16);
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint m, q;
        m = num < 0 ? -num : num;
        q = (2 * m + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    function automatic void paint_dab(int cxq, int cyq);
        int w, h, ir, cx, cy, x0, x1, y0, y1, idx;
        longint unsigned rr, hd, op, hq, rq, d2, cov, dq, num, t, s, k, nv, old;
        longint ddx, ddy;
        w = width_used();
        h = height_used();
        if (w == 0 || h == 0) return;
        rr = radius_q < 16 ? 16 : radius_q;
        hd = hard_q > 256 ? 256 : hard_q;
        op = opac_q > 256 ? 256 : opac_q;
        hq = rr * hd;
        rq = rr * 256;
        ir = int'((rr + 15) / 16);
        cx = half16(cxq);
        cy = half16(cyq);
        x0 = cx - ir < 0 ? 0 : cx - ir;
        x1 = cx + ir > w - 1 ? w - 1 : cx + ir;
        y0 = cy - ir < 0 ? 0 : cy - ir;
        y1 = cy + ir > h - 1 ? h - 1 : cy + ir;
        for (int py = y0; py <= y1; py++) begin
            for (int px = x0; px <= x1; px++) begin
                ddx = longint'(px) * 16 - cxq;
                ddy = longint'(py) * 16 - cyq;
                d2 = ddx * ddx + ddy * ddy;
                if (d2 > rr * rr) continue;
                if (d2 * 65536 <= hq * hq) begin
                    cov = 65536;       // hard core
                end else if (rq <= hq) begin
                    cov = 0;
                end else begin
                    dq = int_sqrt(d2 * 65536);
                    num = dq > hq ? dq - hq : 0;
                    t = (num << 16) / (rq - hq);
                    if (t > 65536) t = 65536;
                    s = (t * t * (3 * 65536 - 2 * t) + (64'd1 << 31)) >> 32;
                    cov = s >= 65536 ? 0 : 65536 - s;
                end
                idx = py * MW + px;
                old = mask_img[idx];
                k = cov * op;
                if (!stroke_sub) begin
                    nv = (k * 255 + (64'd1 << 23)) >> 24;
                    if (old > nv) nv = old;
                end else begin
                    nv = (old * ((64'd1 << 24) - k) + (64'd1 << 23)) >> 24;
                end
                mask_img[idx] = nv > 255 ? 8'd255 : nv[7:0];
            end
        end
    endfunction

    function automatic logic [1:0] move_brush(int x, int y);
        longint dx, dy;
        longint unsigned d2, rr, sp, q, s, n;
        if (!stroke_on || width_used() == 0 || height_used() == 0)
            return sbmp_pkg::STAT_IGNORED;
        dx = longint'(x) - prev_x;
        dy = longint'(y) - prev_y;
        d2 = dx * dx + dy * dy;
        if (d2 == 0) begin
            paint_dab(x, y);   // zero-length move stamps once
        end else begin
            rr = radius_q < 16 ? 16 : radius_q;
            sp = rr < 64 ? 64 : rr;     // spacing in 1/64 px
            q = 16 * d2;
            s = int_sqrt(q);
            n = (s * s == q) ? (s + sp - 1) / sp : (s + sp) / sp;
            if (n > MAXD) n = MAXD;
            if (n < 1) n = 1;
            for (longint i = 1; i <= longint'(n); i++)
                paint_dab(int'(prev_x + round_div(i * dx, longint'(n))),
                          int'(prev_y + round_div(i * dy, longint'(n))));
        end
        prev_x = x;
        prev_y = y;
        return sbmp_pkg::STAT_DONE;
    endfunction

    function automatic paint_result_t predict_request(logic [2:0] kind, int x, int y,
            logic er, int col, int row, logic [7:0] val);
        paint_result_t res;
        int w, h;
        w = width_used();
        h = height_used();
        res.value = 0;
        res.status = sbmp_pkg::STAT_IGNORED;
        case (kind)
            sbmp_pkg::REQ_LOAD, sbmp_pkg::REQ_READ: begin
                if (col >= w || row >= h) begin
                    res.status = sbmp_pkg::STAT_RANGE;
                end else begin
                    if (kind == sbmp_pkg::REQ_LOAD) mask_img[row*MW + col] = val;
                    else res.value = mask_img[row*MW + col];
                    res.status = sbmp_pkg::STAT_DONE;
                end
            end
            sbmp_pkg::REQ_BEGIN: begin
                // stroke is recorded even without a mask
                stroke_sub = er;
                stroke_on = 1;
                prev_x = x;
                prev_y = y;
                if (w != 0 && h != 0) begin
                    paint_dab(x, y);
                    res.status = sbmp_pkg::STAT_DONE;
                end
            end
            sbmp_pkg::REQ_MOVE: res.status = move_brush(x, y);
            sbmp_pkg::REQ_END: begin
                stroke_on = 0;
                res.status = sbmp_pkg::STAT_DONE;
            end
            sbmp_pkg::REQ_CLEAR, sbmp_pkg::REQ_FILL: begin
                if (w != 0 && h != 0) begin
                    for (int r = 0; r < h; r++)
                        for (int c = 0; c < w; c++)
                            mask_img[r*MW + c] = kind == sbmp_pkg::REQ_CLEAR ? 8'd0 : 8'd255;
                    res.status = sbmp_pkg::STAT_DONE;
                end
            end
            default: ;          // unknown kind: ignored
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    task automatic send_req(logic [2:0] kind, logic signed [15:0] x, logic signed [15:0] y,
            logic er, logic [7:0] col, logic [7:0] row, logic [7:0] val);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
        pending_results.push_back(predict_request(kind, int'(x), int'(y), er,
                                                  int'(col), int'(row), val));
        items_sent++;
        if (gap != 0) begin
            i_s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tuser <= kind;
        i_s_axis_tdata <= {7'd0, val, row, col, er, y, x};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic pix_load(logic [7:0] col, logic [7:0] row, logic [7:0] val);
        send_req(sbmp_pkg::REQ_LOAD, 16'($urandom), 16'($urandom), 1'($urandom), col, row,
                 val);
    endtask

    task automatic pix_read(logic [7:0] col, logic [7:0] row);
        send_req(sbmp_pkg::REQ_READ, 16'($urandom), 16'($urandom), 1'($urandom), col, row,
                 8'($urandom));
    endtask

    task automatic stroke_req(logic [2:0] kind, logic signed [15:0] x,
            logic signed [15:0] y, logic er);
        send_req(kind, x, y, er, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic plain_req(logic [2:0] kind);
        send_req(kind, 16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
    endtask

    // every result in, plus slack for the block to settle
    task automatic wait_idle();
        i_s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [sbmp_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= sbmp_pkg::CFG_DATA_W'(val);
        case (idx)
            sbmp_pkg::CFG_ACTIVE_WIDTH:   act_w = val & 9'h1FF;
            sbmp_pkg::CFG_ACTIVE_HEIGHT:  act_h = val & 9'h1FF;
            sbmp_pkg::CFG_BRUSH_RADIUS:   radius_q = val & 13'h1FFF;
            sbmp_pkg::CFG_BRUSH_HARDNESS: hard_q = val & 9'h1FF;
            sbmp_pkg::CFG_BRUSH_OPACITY:  opac_q = val & 9'h1FF;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // write all five registers back to back; only while idle
    task automatic set_brush(int unsigned w, int unsigned h, int unsigned r,
            int unsigned hd, int unsigned op);
        wait_idle();
        cfg_write(sbmp_pkg::CFG_ACTIVE_WIDTH, w);
        cfg_write(sbmp_pkg::CFG_ACTIVE_HEIGHT, h);
        cfg_write(sbmp_pkg::CFG_BRUSH_RADIUS, r);
        cfg_write(sbmp_pkg::CFG_BRUSH_HARDNESS, hd);
        cfg_write(sbmp_pkg::CFG_BRUSH_OPACITY, op);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Result side: check each transfer, drive tready with stalls
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        paint_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata !== want.value) begin
                    $error("read_value expected %0d actual %0d", want.value, o_m_axis_tdata);
                    err_count++;
                end
                if (o_m_axis_tuser !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_m_axis_tuser);
                    err_count++;
                end
            end
        end
        if (hold_cnt != 0) begin
            i_m_axis_tready <= 0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_m_axis_tready <= 0;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 12);
            i_m_axis_tready <= 0;
        end else begin
            i_m_axis_tready <= 1;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go = 0;
            hold_cnt <= 400;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("soft_brush_mask_painter test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // no mask: range on load/read, ignored paint ops, begin still recorded
    task automatic test_no_mask();
        set_brush(0, 0, 16, 0, 256);
        pix_load(0, 0, 8'hA5);
        pix_read(8'hFF, 8'hFF);
        plain_req(sbmp_pkg::REQ_CLEAR);
        plain_req(sbmp_pkg::REQ_FILL);
        stroke_req(sbmp_pkg::REQ_MOVE, 16, 16, 0);
        stroke_req(sbmp_pkg::REQ_BEGIN, 32, 32, 1);
        stroke_req(sbmp_pkg::REQ_MOVE, 64, 32, 0);
        plain_req(sbmp_pkg::REQ_END);
        plain_req(3'd7);
    endtask

    // oversize width clamps to the memory; fill reaches the last pixel
    task automatic test_full_mask();
        set_brush(511, 256, 16, 0, 256);
        plain_req(sbmp_pkg::REQ_FILL);
        pix_read(8'd255, 8'd255);
        pix_load(8'd0, 8'd0, 8'd0);
        pix_read(8'd0, 8'd0);
        set_brush(10, 5, 16, 0, 256);
        pix_read(8'd10, 8'd0);
        pix_load(8'd0, 8'd5, 8'd1);
        pix_read(8'd9, 8'd4);
    endtask

    task automatic test_directed_strokes();
        // radius below one pixel is used as one pixel
        set_brush(32, 32, 0, 0, 256);
        plain_req(sbmp_pkg::REQ_CLEAR);
        stroke_req(sbmp_pkg::REQ_BEGIN, 160, 160, 0);
        stroke_req(sbmp_pkg::REQ_MOVE, 160, 160, 0);
        stroke_req(sbmp_pkg::REQ_MOVE, 400, 168, 0);
        pix_read(8'd15, 8'd10);
        plain_req(sbmp_pkg::REQ_END);
        stroke_req(sbmp_pkg::REQ_MOVE, 100, 100, 0);
        // oversize hardness and opacity, huge radius on a tiny mask, erase
        set_brush(8, 8, 8191, 511, 511);
        plain_req(sbmp_pkg::REQ_FILL);
        stroke_req(sbmp_pkg::REQ_BEGIN, 40, 40, 1);
        pix_read(8'd7, 8'd7);
        set_brush(8, 8, 96, 128, 200);
        plain_req(sbmp_pkg::REQ_FILL);
        stroke_req(sbmp_pkg::REQ_BEGIN, 24, 24, 1);
        pix_read(8'd3, 8'd2);
        // full-range diagonal, far off the mask at both ends
        set_brush(8, 8, 16, 0, 256);
        stroke_req(sbmp_pkg::REQ_BEGIN, -16'sd32768, -16'sd32768, 0);
        stroke_req(sbmp_pkg::REQ_MOVE, 16'sd32767, 16'sd32767, 0);
        pix_read(8'd4, 8'd4);
        plain_req(sbmp_pkg::REQ_END);
    endtask

    // sender keeps offering while the receiver holds off
    task automatic test_backpressure();
        set_brush(16, 16, 16, 0, 256);
        hold_go = 1;
        for (int i = 0; i < 6; i++) pix_read(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
    endtask

    function automatic logic signed [15:0] rand_point(int span);
        if ($urandom_range(0, 49) == 0) return 16'($urandom);
        return 16'($urandom_range(0, span * 16 + 64)) - 16'sd32;
    endfunction

    task automatic test_random_strokes();
        int phase, w, h, span, pick, nmov;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 24);
            case (phase % 5)
                1: set_brush(0, $urandom_range(0, 20), 16, 0, 256);
                2: begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(1, 3);
                    set_brush(w, h, $urandom_range(2000, 8191), $urandom_range(0, 511),
                              $urandom_range(0, 511));
                end
                3: set_brush(w, h, $urandom_range(0, 15), $urandom_range(0, 300), 256);
                default: set_brush(w, h, $urandom_range(16, 40), $urandom_range(0, 511),
                                   $urandom_range(0, 511));
            endcase
            span = w > h ? w : h;
            for (int i = 0; i < 20 && items_sent < RANDOM_ITEMS; i++) begin
                if (items_sent > RANDOM_ITEMS - 30) idle_en = 0;    // no idling at the end
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    stroke_req(sbmp_pkg::REQ_BEGIN, rand_point(span), rand_point(span),
                               1'($urandom));
                    nmov = $urandom_range(1, 4);
                    for (int m = 0; m < nmov; m++)
                        stroke_req(sbmp_pkg::REQ_MOVE, rand_point(span), rand_point(span),
                                   1'($urandom));
                    if ($urandom_range(0, 5) != 0) plain_req(sbmp_pkg::REQ_END);
                end else if (pick < 66) begin
                    pix_load(8'($urandom), 8'($urandom), 8'($urandom));
                end else if (pick < 78) begin
                    if ($urandom_range(0, 1) != 0)
                        pix_read(8'($urandom_range(0, w)), 8'($urandom_range(0, h)));
                    else
                        pix_read(8'($urandom), 8'($urandom));
                end else if (pick < 84) begin
                    plain_req($urandom_range(0, 1) != 0 ? sbmp_pkg::REQ_CLEAR
                                                        : sbmp_pkg::REQ_FILL);
                end else if (pick < 92) begin
                    stroke_req(sbmp_pkg::REQ_MOVE, rand_point(span), rand_point(span),
                               1'($urandom));
                end else begin
                    plain_req(3'd7);
                end
            end
            phase++;
        end
    endtask

    initial begin
        act_w = 0; act_h = 0; radius_q = 16; hard_q = 0; opac_q = 256;
        stroke_on = 0; stroke_sub = 0; prev_x = 0; prev_y = 0;
        foreach (mask_img[i]) mask_img[i] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        test_no_mask();
        test_full_mask();
        test_directed_strokes();
        test_backpressure();
        test_random_strokes();

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("soft_brush_mask_painter test passed");
        end else begin
            $display("soft_brush_mask_painter test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sbmp_pkg.sv
sv/sbmp_mem.sv
sv/sbmp_isqrt.sv
sv/sbmp_div.sv
sv/soft_brush_mask_painter.sv
sv/sbmp_checker.sv
dv/tb.sv
